[rtl/size_sorted_free_list_defines.svh]
// Assertion macros shared by the size_sorted_free_list checkers.
`ifndef SIZE_SORTED_FREE_LIST_DEFINES_SVH
`define SIZE_SORTED_FREE_LIST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSFL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSFL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ssfl_pkg.sv]
// Types, sizes and codes for the size-sorted free list.
package ssfl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int SLOT_W   = 6;
  localparam int CNTO_W   = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] entry_size;
    logic [31:0] entry_offset;
    logic [30:0] entry_key;
    logic [5:0]  position;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic [6:0]  count_after;
    logic [15:0] out_size;
    logic [31:0] out_offset;
    logic [30:0] out_key;
  } out_t;

  // One table row
  typedef struct packed {
    logic [15:0] size;
    logic [31:0] offset;
    logic [30:0] key;
  } entry_t;

  // Top level to core
  typedef struct packed {
    logic start;
    logic ack;
  } core_ctl_t;

  // Core to top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

[rtl/ssfl_core.sv]
// Table memory and the search/shift sequencer of the size-sorted free list.
module ssfl_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssfl_pkg::core_ctl_t    ctl,
  input  ssfl_pkg::in_t          cmd,
  output ssfl_pkg::core_stat_t   stat,
  output ssfl_pkg::out_t         res
);

  localparam int CNT_W = ssfl_pkg::CNT_W;
  localparam int IDX_W = ssfl_pkg::IDX_W;
  localparam int CMP_W = ssfl_pkg::CMP_W;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH_RD  = 9'b000000010,
    S_SRCH_CMP = 9'b000000100,
    S_SHIFT_UP = 9'b000001000,
    S_PUT      = 9'b000010000,
    S_RM_RD    = 9'b000100000,
    S_RM_CAP   = 9'b001000000,
    S_SHIFT_DN = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  ssfl_pkg::in_t        cmd_r;
  ssfl_pkg::out_t       res_r, res_nxt;

  // Table memory: one write port, one registered read port
  ssfl_pkg::entry_t     mem [ssfl_pkg::CAPACITY];
  ssfl_pkg::entry_t     rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  ssfl_pkg::entry_t     wr_data;

  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid;
  logic [CNT_W:0]       i_ext;
  logic [CNT_W:0]       cnt_ext;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Midpoint of the upper-bound search window
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign i_ext   = {1'b0, i_r};
  assign cnt_ext = {1'b0, count_r};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    res_nxt   = res_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          res_nxt.out_size   = '0;
          res_nxt.out_offset = '0;
          res_nxt.out_key    = '0;
          res_nxt.slot       = '0;
          res_nxt.count_after = ssfl_pkg::CNTO_W'(count_r);
          if (cmd.op == ssfl_pkg::OP_INSERT) begin
            if (count_r == CNT_W'(ssfl_pkg::CAPACITY)) begin
              res_nxt.status = ssfl_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              state_nxt = S_SRCH_RD;
            end
          end else begin
            if (CMP_W'(cmd.position) >= CMP_W'(count_r)) begin
              res_nxt.status = ssfl_pkg::ST_BAD_POS;
              state_nxt      = S_DONE;
            end else begin
              i_nxt     = CNT_W'(cmd.position);
              state_nxt = S_RM_RD;
            end
          end
        end
      end

      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          rd_addr   = IDX_W'(mid);
          state_nxt = S_SRCH_CMP;
        end else if (count_r > lo_r) begin
          // first move of the upward shift: top entry goes one place up
          rd_addr   = IDX_W'(count_r - CNT_W'(1));
          i_nxt     = count_r;
          state_nxt = S_SHIFT_UP;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_SRCH_CMP: begin
        if (rd_data_r.size > cmd_r.entry_size) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + CNT_W'(1);
        end
        state_nxt = S_SRCH_RD;
      end

      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(i_r);
        if ((i_r - CNT_W'(1)) > lo_r) begin
          rd_addr = IDX_W'(i_r - CNT_W'(2));
          i_nxt   = i_r - CNT_W'(1);
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        wr_en               = 1'b1;
        wr_addr             = IDX_W'(lo_r);
        wr_data.size        = cmd_r.entry_size;
        wr_data.offset      = cmd_r.entry_offset;
        wr_data.key         = cmd_r.entry_key;
        count_nxt           = count_r + CNT_W'(1);
        res_nxt.status      = ssfl_pkg::ST_OK;
        res_nxt.slot        = ssfl_pkg::SLOT_W'(lo_r);
        res_nxt.count_after = ssfl_pkg::CNTO_W'(count_r + CNT_W'(1));
        state_nxt           = S_DONE;
      end

      S_RM_RD: begin
        rd_addr   = IDX_W'(i_r);
        state_nxt = S_RM_CAP;
      end

      S_RM_CAP: begin
        res_nxt.status     = ssfl_pkg::ST_OK;
        res_nxt.slot       = ssfl_pkg::SLOT_W'(i_r);
        res_nxt.out_size   = rd_data_r.size;
        res_nxt.out_offset = rd_data_r.offset;
        res_nxt.out_key    = rd_data_r.key;
        if ((i_ext + (CNT_W+1)'(1)) < cnt_ext) begin
          rd_addr   = IDX_W'(i_r + CNT_W'(1));
          state_nxt = S_SHIFT_DN;
        end else begin
          count_nxt           = count_r - CNT_W'(1);
          res_nxt.count_after = ssfl_pkg::CNTO_W'(count_r - CNT_W'(1));
          state_nxt           = S_DONE;
        end
      end

      S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = IDX_W'(i_r);
        if ((i_ext + (CNT_W+1)'(2)) < cnt_ext) begin
          rd_addr = IDX_W'(i_r + CNT_W'(2));
          i_nxt   = i_r + CNT_W'(1);
        end else begin
          count_nxt           = count_r - CNT_W'(1);
          res_nxt.count_after = ssfl_pkg::CNTO_W'(count_r - CNT_W'(1));
          state_nxt           = S_DONE;
        end
      end

      S_DONE: begin
        if (ctl.ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    res_r <= res_nxt;
    if (state_r == S_IDLE && ctl.start) begin
      cmd_r <= cmd;
    end
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res            = res_r;

endmodule

[rtl/size_sorted_free_list.sv]
// Top level of the size-sorted free list: handshakes and output register.
//
// Keeps up to 64 freed slots (size, offset, key) in ascending size order.
// Input words (in_valid/in_ready, in_data) carry either an insert, which
// places the slot after every entry of equal or smaller size, or a remove,
// which returns the entry at a position and closes the gap. Every input
// word gives exactly one result word on out_valid/out_ready, out_data.
// Items are handled one at a time by a sequencer around a table RAM with
// one write port and a registered read port, so in_ready is low meanwhile.
// An insert runs a binary search for the landing slot, then moves every
// entry at or above that slot up one place, one row per cycle; a remove
// reads the entry at the position, then moves the entries above it down
// one place. A full table or a bad position finishes with no change.
// Result words sit in an output register; the next input word is taken
// while an earlier result still waits, and the core holds its finished
// result if the receiver stalls. Reset (rst_n low, synchronous) empties
// the table; table contents are not cleared, only the count.
module size_sorted_free_list (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssfl_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ssfl_pkg::out_t  out_data
);

  ssfl_pkg::core_ctl_t  ctl;
  ssfl_pkg::core_stat_t stat;
  ssfl_pkg::out_t       res;
  logic                 out_valid_r, out_valid_nxt;
  ssfl_pkg::out_t       out_data_r;

  ssfl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .cmd   (in_data),
    .stat  (stat),
    .res   (res)
  );

  // Input side: take a word whenever the core is idle
  assign in_ready  = stat.idle;
  assign ctl.start = in_valid & stat.idle;

  // Output register loads when empty or being drained
  assign ctl.ack = stat.res_valid & (~out_valid_r | out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/ssfl_checker.sv]
// Port-level checker for the size-sorted free list, bound to the top level.
`include "size_sorted_free_list_defines.svh"

module ssfl_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ssfl_pkg::out_t  out_data
);

  // A held result word must not change
  `SSFL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")

  // One item at a time: an accepted word drops ready
  `SSFL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after an accept")

  // Only defined status codes appear
  `SSFL_ASSERT_IMP(a_status_code, out_valid, out_data.status == ssfl_pkg::ST_OK || out_data.status == ssfl_pkg::ST_FULL || out_data.status == ssfl_pkg::ST_BAD_POS, "undefined status code")

  // Rejected operations return an empty payload
  `SSFL_ASSERT_IMP(a_reject_empty, out_valid && out_data.status != ssfl_pkg::ST_OK, out_data.slot == '0 && out_data.out_size == '0 && out_data.out_offset == '0 && out_data.out_key == '0, "rejected word has nonzero payload")

endmodule

bind size_sorted_free_list ssfl_checker u_ssfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
